FILE: rtl/http_response_header_classifier_top_defines.svh
// Assertion macros shared by the header classifier RTL.
`ifndef HTTP_RESPONSE_HEADER_CLASSIFIER_TOP_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_CLASSIFIER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define HRHC_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define HRHC_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hrhc_pkg.sv
// Package with types, constants and the name table of the header classifier.
package hrhc_pkg;

    localparam int NUM_NAMES    = 22;
    localparam int MAX_NAME_LEN = 32;
    localparam int NAME_BYTES   = 32;
    localparam int POS_W        = 6;
    localparam int CLASS_W      = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0]     POS_MAX        = '1;
    localparam logic [NUM_NAMES-1:0] ALL_CANDIDATES = '1;
    localparam logic [CLASS_W-1:0]   CLASS_UNKNOWN  = '0;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE_OFFSET = 8'h20;

    localparam logic [NAME_BYTES*8-1:0] NAME_TABLE [NUM_NAMES] = '{
        "date", "etag", "vary", "allow", "server", "location", "connection",
        "set-cookie", "content-type", "accept-ranges", "cache-control",
        "content-range", "last-modified", "content-length", "content-encoding",
        "transfer-encoding", "access-control-allow-origin",
        "access-control-allow-methods", "access-control-allow-headers",
        "access-control-max-age", "access-control-expose-headers",
        "access-control-allow-credentials"
    };

    localparam logic [POS_W-1:0] NAME_LEN [NUM_NAMES] = '{
        6'd4, 6'd4, 6'd4, 6'd5, 6'd6, 6'd8, 6'd10, 6'd10, 6'd12, 6'd13, 6'd13,
        6'd13, 6'd13, 6'd14, 6'd16, 6'd17, 6'd27, 6'd28, 6'd28, 6'd22, 6'd29,
        6'd32
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } item_t;

    // Byte of name k at position pos; only meaningful while pos is below its length.
    function automatic logic [7:0] name_byte(input int k, input logic [POS_W-1:0] pos);
        int sh;
        sh = (int'(NAME_LEN[k]) - 1 - int'(pos)) * 8;
        if (sh < 0)
        begin
            sh = 0;
        end
        return NAME_TABLE[k][sh +: 8];
    endfunction

endpackage

FILE: rtl/hrhc_if.sv
// Stream interfaces for header name bytes and class results.
interface hrhc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       has_char;
    logic       last;

    modport source (output valid, output ch, output has_char, output last, input ready);
    modport sink (input valid, input ch, input has_char, input last, output ready);
endinterface

interface hrhc_class_if;
    logic       valid;
    logic       ready;
    logic [4:0] header_class;

    modport source (output valid, output header_class, input ready);
    modport sink (input valid, input header_class, output ready);
endinterface

FILE: rtl/hrhc_front.sv
// Front end: accepts bytes, folds letter case and drops items that carry nothing.
module hrhc_front
    import hrhc_pkg::*;
(
    hrhc_byte_if.sink bytes,
    input  logic      q_ready,
    output logic      push,
    output item_t     push_item
);

    logic is_upper;

    assign is_upper = (bytes.ch >= ASCII_UPPER_A) && (bytes.ch <= ASCII_UPPER_Z);

    assign bytes.ready        = q_ready;
    assign push               = bytes.valid && q_ready && (bytes.has_char || bytes.last);
    assign push_item.ch       = is_upper ? (bytes.ch + ASCII_CASE_OFFSET) : bytes.ch;
    assign push_item.has_char = bytes.has_char;
    assign push_item.last     = bytes.last;

endmodule

FILE: rtl/hrhc_queue.sv
// Short queue of folded items between the front and back ends.
`include "http_response_header_classifier_top_defines.svh"
module hrhc_queue
    import hrhc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  ready,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    item_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_next;

    assign ready     = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `HRHC_ALWAYS(a_queue_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `HRHC_ALWAYS(a_pop_nonempty, !pop || pop_valid, "pop from an empty queue")

endmodule

FILE: rtl/hrhc_back.sv
// Back end: candidate mask, position count and the registered class result.
`include "http_response_header_classifier_top_defines.svh"
module hrhc_back
    import hrhc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  item_t         q_item,
    output logic          pop,
    hrhc_class_if.source  result
);

    logic [NUM_NAMES-1:0] candidates_reg;
    logic [NUM_NAMES-1:0] candidates_next;
    logic [POS_W-1:0]     position_reg;
    logic [POS_W-1:0]     position_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic [CLASS_W-1:0]   class_reg;
    logic [CLASS_W-1:0]   class_next;
    logic [NUM_NAMES-1:0] cand_step;
    logic [POS_W-1:0]     pos_step;
    logic [CLASS_W-1:0]   class_found;
    logic                 out_free;

    assign out_free = !valid_reg || result.ready;
    assign pop      = q_valid && (!q_item.last || out_free);

    always_comb
    begin
        cand_step = candidates_reg;
        pos_step  = position_reg;
        if (q_item.has_char)
        begin
            if (position_reg >= POS_W'(MAX_NAME_LEN))
            begin
                cand_step = '0;
            end
            else
            begin
                for (int k = 0; k < NUM_NAMES; k++)
                begin
                    if (!((position_reg < NAME_LEN[k]) &&
                          (q_item.ch == name_byte(k, position_reg))))
                    begin
                        cand_step[k] = 1'b0;
                    end
                end
            end
            if (position_reg != POS_MAX)
            begin
                pos_step = position_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        class_found = CLASS_UNKNOWN;
        for (int k = NUM_NAMES - 1; k >= 0; k--)
        begin
            if (cand_step[k] && (NAME_LEN[k] == pos_step))
            begin
                class_found = CLASS_W'(k + 1);
            end
        end
    end

    always_comb
    begin
        candidates_next = candidates_reg;
        position_next   = position_reg;
        valid_next      = valid_reg && !result.ready;
        class_next      = class_reg;
        if (pop)
        begin
            if (q_item.last)
            begin
                candidates_next = ALL_CANDIDATES;
                position_next   = '0;
                valid_next      = 1'b1;
                class_next      = class_found;
            end
            else
            begin
                candidates_next = cand_step;
                position_next   = pos_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            candidates_reg <= ALL_CANDIDATES;
            position_reg   <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            candidates_reg <= candidates_next;
            position_reg   <= position_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
    end

    assign result.valid        = valid_reg;
    assign result.header_class = class_reg;

    `HRHC_NEXT(a_restart, pop && q_item.last, position_reg == '0 && candidates_reg == ALL_CANDIDATES, "state not restarted after a name")
    `HRHC_ALWAYS(a_fresh_mask, position_reg != '0 || candidates_reg == ALL_CANDIDATES, "candidates cleared before any byte")
    `HRHC_ALWAYS(a_class_range, !valid_reg || class_reg <= CLASS_W'(NUM_NAMES), "class code out of range")

endmodule

FILE: rtl/http_response_header_classifier_top.sv
// Top level of the HTTP response header name classifier.
//
// Channel   Direction  Fields                   Handshake
// bytes     in         ch, has_char, last       valid/ready
// result    out        header_class             valid/ready
//
// A byte item is taken every cycle the queue has room; the class result is registered.
// The two-entry queue lets the input keep flowing while a result waits on the output.
// Reset is asynchronous and active low; it clears the queue, the mask and the output.
// A stalled result holds only items that end a name; other bytes still advance the match.
module http_response_header_classifier_top
    import hrhc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hrhc_byte_if.sink     bytes,
    hrhc_class_if.source  result
);

    logic  push;
    item_t push_item;
    logic  q_ready;
    logic  pop;
    logic  q_valid;
    item_t q_item;

    hrhc_front u_front (
        .bytes     (bytes),
        .q_ready   (q_ready),
        .push      (push),
        .push_item (push_item)
    );

    hrhc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (q_ready),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    hrhc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .result  (result)
    );

endmodule

FILE: tb/sv/http_response_header_classifier_top_tb.sv
// Self-checking testbench for the HTTP response header name classifier.
module http_response_header_classifier_top_tb;
    import hrhc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_COUNT    = 22;
    localparam int LONGEST_NAME  = 32;
    localparam int BYTE_POS_MAX  = 63;
    localparam int ITEM_TARGET   = 850;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int IDLE_PERCENT  = 36;

    logic clk;
    logic rst_n;

    hrhc_byte_if  bytes_if ();
    hrhc_class_if class_if ();

    http_response_header_classifier_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes_if),
        .result (class_if)
    );

    string name_list [NAME_COUNT] = '{
        "date", "etag", "vary", "allow", "server", "location", "connection",
        "set-cookie", "content-type", "accept-ranges", "cache-control",
        "content-range", "last-modified", "content-length", "content-encoding",
        "transfer-encoding", "access-control-allow-origin",
        "access-control-allow-methods", "access-control-allow-headers",
        "access-control-max-age", "access-control-expose-headers",
        "access-control-allow-credentials"
    };

    logic [NAME_COUNT-1:0] live_names;
    logic [POS_W-1:0]      byte_pos;
    logic [CLASS_W-1:0]    expected_classes [$];
    logic [7:0]            name_buf [$];

    int items_sent;
    int mismatch_count;
    bit steady;
    bit gap_items;
    bit hold_start;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic void classify_byte(input logic [7:0] c, input bit has, input bit fin);
        logic [7:0]         b;
        logic [CLASS_W-1:0] cls;
        b = lower_case(c);
        if (has)
        begin
            if (byte_pos >= LONGEST_NAME)
            begin
                live_names = '0;
            end
            else
            begin
                for (int k = 0; k < NAME_COUNT; k++)
                begin
                    if (!(byte_pos < name_list[k].len() &&
                          name_list[k].getc(int'(byte_pos)) == b))
                    begin
                        live_names[k] = 1'b0;
                    end
                end
            end
            if (byte_pos != BYTE_POS_MAX)
            begin
                byte_pos = byte_pos + 1'b1;
            end
        end
        if (fin)
        begin
            cls = CLASS_UNKNOWN;
            for (int k = NAME_COUNT - 1; k >= 0; k--)
            begin
                if (live_names[k] && name_list[k].len() == int'(byte_pos))
                begin
                    cls = CLASS_W'(k + 1);
                end
            end
            expected_classes.push_back(cls);
            live_names = '1;
            byte_pos = '0;
        end
    endfunction

    task automatic send_item(input logic [7:0] c, input bit has, input bit fin);
        bit taken;
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            bytes_if.valid <= 1'b0;
            @(posedge clk);
        end
        bytes_if.valid    <= 1'b1;
        bytes_if.ch       <= c;
        bytes_if.has_char <= has;
        bytes_if.last     <= fin;
        do
        begin
            @(negedge clk);
            taken = bytes_if.ready;
            @(posedge clk);
        end
        while (!taken);
        classify_byte(c, has, fin);
        if (has || fin)
        begin
            items_sent++;
        end
    endtask

    function automatic void load_name(input string s, input bit mix_case);
        logic [7:0] c;
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            c = s.getc(i);
            if (mix_case && c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1)
            begin
                c = c - 8'h20;
            end
            name_buf.push_back(c);
        end
    endfunction

    task automatic send_name(input bit empty_end);
        for (int i = 0; i < name_buf.size(); i++)
        begin
            if (gap_items && $urandom_range(9) == 0)
            begin
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            send_item(name_buf[i], 1'b1, !empty_end && i == name_buf.size() - 1);
        end
        if (empty_end || name_buf.size() == 0)
        begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_drain();
        bytes_if.valid <= 1'b0;
        while (expected_classes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        name_buf.delete();
        send_name(1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        load_name("DaTe", 1'b0);
        send_name(1'b0);
        load_name("vary", 1'b0);
        send_name(1'b1);
        name_buf.delete();
        name_buf.push_back(8'h00);
        send_name(1'b0);
        name_buf[0] = 8'hFF;
        send_name(1'b0);
        load_name("ALLO", 1'b0);
        send_name(1'b0);
        load_name("etag-", 1'b0);
        send_name(1'b0);
        wait_drain();
    endtask

    task automatic test_every_name();
        steady = 1'b1;
        for (int k = 0; k < NAME_COUNT; k++)
        begin
            load_name(name_list[k], 1'b1);
            send_name(1'($urandom_range(1)));
        end
        wait_drain();
        steady = 1'b0;
    endtask

    task automatic test_long_names();
        load_name(name_list[NAME_COUNT-1], 1'b1);
        send_name(1'b0);
        name_buf.push_back(8'h53);
        send_name(1'($urandom_range(1)));
        load_name(name_list[NAME_COUNT-1], 1'b1);
        void'(name_buf.pop_back());
        send_name(1'b0);
        name_buf.delete();
        for (int i = 0; i < 70; i++)
        begin
            name_buf.push_back(8'($urandom_range(8'h7A, 8'h61)));
        end
        send_name(1'($urandom_range(1)));
        wait_drain();
    endtask

    task automatic test_output_stall();
        hold_start = 1'b1;
        for (int n = 0; n < 12; n++)
        begin
            load_name(name_list[$urandom_range(NAME_COUNT - 1)], 1'b1);
            if (n % 3 == 0)
            begin
                load_name("etag", 1'b1);
            end
            send_name($urandom_range(3) == 0);
        end
        wait_drain();
    endtask

    task automatic test_random_names();
        int pick;
        int len;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                load_name(name_list[$urandom_range(NAME_COUNT - 1)], 1'b1);
                case ($urandom_range(5))
                    1: name_buf[$urandom_range(name_buf.size() - 1)] = 8'($urandom_range(255));
                    2: void'(name_buf.pop_back());
                    3: name_buf.push_back(8'($urandom_range(255)));
                    default: ;
                endcase
            end
            else if (pick < 88)
            begin
                name_buf.delete();
                len = $urandom_range(8);
                for (int i = 0; i < len; i++)
                begin
                    name_buf.push_back(8'($urandom_range(255)));
                end
            end
            else
            begin
                load_name(name_list[NAME_COUNT-1], 1'b1);
                len = $urandom_range(40, 28);
                while (name_buf.size() > len)
                begin
                    void'(name_buf.pop_back());
                end
                while (name_buf.size() < len)
                begin
                    name_buf.push_back($urandom_range(1) ? 8'h2D : 8'($urandom_range(8'h7A, 8'h61)));
                end
            end
            gap_items = $urandom_range(3) == 0;
            send_name($urandom_range(3) == 0);
        end
        gap_items = 1'b0;
        wait_drain();
    endtask

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (bytes_if.valid && bytes_if.ready) ||
                (class_if.valid && class_if.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        class_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                class_if.ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                class_if.ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
            end
        end
    end

    always @(negedge clk)
    begin
        logic [CLASS_W-1:0] want;
        if (rst_n && class_if.valid && class_if.ready)
        begin
            if (expected_classes.size() == 0)
            begin
                $error("header_class: expected none, actual %0d", class_if.header_class);
                mismatch_count++;
            end
            else
            begin
                want = expected_classes.pop_front();
                if (class_if.header_class !== want)
                begin
                    $error("header_class: expected %0d, actual %0d", want,
                           class_if.header_class);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        bytes_if.valid    <= 1'b0;
        bytes_if.ch       <= 8'h00;
        bytes_if.has_char <= 1'b0;
        bytes_if.last     <= 1'b0;
        live_names = '1;
        byte_pos = '0;
        items_sent = 0;
        mismatch_count = 0;
        steady = 1'b0;
        gap_items = 1'b0;
        hold_start = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_every_name();
        test_long_names();
        test_output_stall();
        test_random_names();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_classes.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
